@@ rtl/logistic_loss_with_derivatives_core_macros.svh @@
`ifndef LOGISTIC_LOSS_WITH_DERIVATIVES_CORE_MACROS_SVH
`define LOGISTIC_LOSS_WITH_DERIVATIVES_CORE_MACROS_SVH

// same-cycle implication
`define LLWD_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LLWD_ASSERT_NXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/llwd_pkg.sv @@
package llwd_pkg;

  localparam int TW = 30;
  localparam logic [30:0] ONE = 31'h4000_0000;

  typedef logic [TW-1:0] entry_t;

  typedef struct packed {
    logic        valid;
    logic        neg;
    logic        in_range;
    logic        lab_pos;
    logic [31:0] frac;
    logic [38:0] a;
    logic [15:0] labmag;
    logic [30:0] ll;
  } front_t;

  typedef struct packed {
    entry_t sp0;
    entry_t sp1;
    entry_t sg0;
    entry_t sg1;
  } rom_data_t;

  typedef struct packed {
    logic        valid;
    logic        lab_pos;
    logic [15:0] labmag;
    logic [30:0] ll;
    logic [41:0] loss_raw;
    logic [30:0] sig;
  } mid_t;

endpackage

@@ rtl/llwd_front.sv @@
`include "logistic_loss_with_derivatives_core_macros.svh"

module llwd_front #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          acc,
  input  logic signed [15:0]            label,
  input  logic signed [23:0]            model_score,
  output llwd_pkg::front_t              f,
  output logic [$clog2(DEPTH+1)-1:0]    idx
);

  localparam int AW = $clog2(DEPTH + 1);
  localparam int PW = 32 + AW;

  logic               v1;
  logic signed [39:0] m1;
  logic [15:0]        labmag1;
  logic               lab_pos1;

  logic               neg;
  logic [38:0]        a;
  logic [PW-1:0]      pos;
  logic [31:0]        ll_full;

  // stage 1: margin product
  always_ff @(posedge clk) begin
    m1       <= 40'(label) * 40'(model_score);
    labmag1  <= label[15] ? 16'(~label + 16'sd1) : 16'(label);
    lab_pos1 <= !label[15] && (label != 16'sd0);
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= acc;
    end
  end

  // stage 2: magnitude, table position, label square
  always_comb begin
    neg     = m1[39];
    a       = neg ? 39'(~m1 + 40'sd1) : 39'(m1);
    pos     = PW'(a[31:0]) * PW'(DEPTH);
    ll_full = 32'(labmag1) * 32'(labmag1);
  end

  always_ff @(posedge clk) begin
    f.neg      <= neg;
    f.in_range <= (a[38:32] == 7'd0);
    f.lab_pos  <= lab_pos1;
    f.frac     <= pos[31:0];
    f.a        <= a;
    f.labmag   <= labmag1;
    f.ll       <= ll_full[30:0];
    idx        <= pos[PW-1:32];
    if (rst) begin
      f.valid <= 1'b0;
    end else begin
      f.valid <= v1;
    end
  end

  `LLWD_ASSERT_IMP(idx_in_table, clk, rst, f.valid && f.in_range, idx < AW'(DEPTH),
                   "table index past last interval")

endmodule

@@ rtl/llwd_rom.sv @@
module llwd_rom #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk,
  input  logic [$clog2(DEPTH+1)-1:0]    addr,
  output llwd_pkg::rom_data_t           rd
);

  localparam int AW = $clog2(DEPTH + 1);
  localparam logic [63:0] H_STEP = (64'd16 << 30) / 64'(DEPTH);

  typedef llwd_pkg::entry_t rom_arr_t [DEPTH+1];

  function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] dvs);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, dvs}) begin
        r    = r - {1'b0, dvs};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic rom_arr_t build_table(input logic softplus);
    rom_arr_t    tbl;
    logic [63:0] one64;
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] c;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] p;
    logic [63:0] sum;
    one64 = 64'd1 << 30;
    h     = H_STEP;
    term  = one64;
    c     = one64;
    e     = one64;
    for (int k = 1; k <= 24; k++) begin
      term = cdiv(term * h, 64'(k) << 30);
      if (k[0]) begin
        c = c - term;
      end else begin
        c = c + term;
      end
    end
    for (int i = 0; i <= DEPTH; i++) begin
      if (softplus) begin
        den = (64'd2 << 30) + e;
        u   = cdiv((e << 30) + (den >> 1), den);
        u2  = (u * u + (64'd1 << 29)) >> 30;
        p   = u;
        sum = 64'd0;
        for (int n = 1; n < 200; n += 2) begin
          if (p != 64'd0) begin
            sum = sum + cdiv(p, 64'(n));
            p   = (p * u2) >> 30;
          end
        end
        tbl[i] = llwd_pkg::entry_t'(sum << 1);
      end else begin
        den    = one64 + e;
        tbl[i] = llwd_pkg::entry_t'(cdiv((e << 30) + (den >> 1), den));
      end
      e = (e * c + (64'd1 << 29)) >> 30;
    end
    return tbl;
  endfunction

  localparam rom_arr_t SIG_ROM = build_table(1'b0);
  localparam rom_arr_t SP_ROM  = build_table(1'b1);

  logic [AW-1:0] addr_n;

  assign addr_n = addr + AW'(1);

  always_ff @(posedge clk) begin
    rd.sp0 <= SP_ROM[addr];
    rd.sp1 <= SP_ROM[addr_n];
    rd.sg0 <= SIG_ROM[addr];
    rd.sg1 <= SIG_ROM[addr_n];
  end

endmodule

@@ rtl/llwd_lerp.sv @@
`include "logistic_loss_with_derivatives_core_macros.svh"

module llwd_lerp (
  input  logic                 clk,
  input  logic                 rst,
  input  llwd_pkg::front_t     f,
  input  llwd_pkg::rom_data_t  rd,
  output llwd_pkg::mid_t       md
);

  localparam logic [30:0] HALF = 31'h2000_0000;
  localparam int FW = $bits(llwd_pkg::front_t);

  llwd_pkg::front_t f3;
  llwd_pkg::front_t f4;

  logic             sp_up;
  logic             sg_up;
  llwd_pkg::entry_t sp_diff;
  llwd_pkg::entry_t sg_diff;
  logic [61:0]      sp_prod;
  logic [61:0]      sg_prod;

  llwd_pkg::entry_t sp_t0;
  llwd_pkg::entry_t sg_t0;
  logic             sp_up4;
  logic             sg_up4;
  llwd_pkg::entry_t sp_d4;
  llwd_pkg::entry_t sg_d4;

  llwd_pkg::entry_t sp_val;
  llwd_pkg::entry_t sg_val;
  logic [41:0]      loss_next;
  logic [30:0]      sig_next;

  // stage 3: align with table read
  always_ff @(posedge clk) begin
    f3 <= {f.valid && !rst, f[FW-2:0]};
  end

  // stage 4: slope times fraction
  always_comb begin
    sp_up   = rd.sp1 >= rd.sp0;
    sg_up   = rd.sg1 >= rd.sg0;
    sp_diff = sp_up ? rd.sp1 - rd.sp0 : rd.sp0 - rd.sp1;
    sg_diff = sg_up ? rd.sg1 - rd.sg0 : rd.sg0 - rd.sg1;
    sp_prod = 62'(sp_diff) * 62'(f3.frac);
    sg_prod = 62'(sg_diff) * 62'(f3.frac);
  end

  always_ff @(posedge clk) begin
    f4     <= {f3.valid && !rst, f3[FW-2:0]};
    sp_t0  <= rd.sp0;
    sg_t0  <= rd.sg0;
    sp_up4 <= sp_up;
    sg_up4 <= sg_up;
    sp_d4  <= sp_prod[61:32];
    sg_d4  <= sg_prod[61:32];
  end

  // stage 5: interpolated values, negative margin fold
  always_comb begin
    sp_val = llwd_pkg::entry_t'(0);
    sg_val = llwd_pkg::entry_t'(0);
    if (f4.in_range) begin
      sp_val = sp_up4 ? sp_t0 + sp_d4 : sp_t0 - sp_d4;
      sg_val = sg_up4 ? sg_t0 + sg_d4 : sg_t0 - sg_d4;
    end
    if (f4.neg) begin
      loss_next = 42'(sp_val) + (42'(f4.a) << 2);
      sig_next  = llwd_pkg::ONE - 31'(sg_val);
    end else begin
      loss_next = 42'(sp_val);
      sig_next  = 31'(sg_val);
    end
  end

  always_ff @(posedge clk) begin
    md.lab_pos  <= f4.lab_pos;
    md.labmag   <= f4.labmag;
    md.ll       <= f4.ll;
    md.loss_raw <= loss_next;
    md.sig      <= sig_next;
    if (rst) begin
      md.valid <= 1'b0;
    end else begin
      md.valid <= f4.valid;
    end
  end

  `LLWD_ASSERT_IMP(sig_low_half, clk, rst, f4.valid && !f4.neg, sig_next <= HALF,
                   "sigmoid above half for positive margin")
  `LLWD_ASSERT_IMP(sig_high_half, clk, rst, f4.valid && f4.neg, sig_next >= HALF,
                   "sigmoid below half for negative margin")

endmodule

@@ rtl/llwd_deriv.sv @@
`include "logistic_loss_with_derivatives_core_macros.svh"

module llwd_deriv (
  input  logic                clk,
  input  logic                rst,
  input  llwd_pkg::mid_t      md,
  output logic                done,
  output logic [23:0]         loss_value,
  output logic signed [23:0]  gradient,
  output logic [22:0]         curvature
);

  logic        v6;
  logic        v7;
  logic        v8;

  logic [42:0] loss_sum;
  logic [28:0] loss_q;
  logic [23:0] loss6;
  logic [23:0] loss7;
  logic [23:0] loss8;
  logic [23:0] loss9;
  logic [46:0] mag_prod6;
  logic [61:0] q_prod6;
  logic        lab_pos6;
  logic [15:0] labmag6;
  logic [30:0] ll6;
  logic [30:0] ll7;

  logic [47:0] mag_sum;
  logic [23:0] mag_c;
  logic [23:0] g_next;
  logic [62:0] q_sum;
  logic [23:0] g7;
  logic [23:0] g8;
  logic [28:0] q7;
  logic        lab_pos7;

  logic [59:0] curv_prod8;
  logic [60:0] curv_sum;

  // stage 6: loss rounding, derivative products
  always_comb begin
    loss_sum = 43'(md.loss_raw) + 43'd8192;
    loss_q   = loss_sum[42:14];
    loss6    = (loss_q > 29'h0FF_FFFF) ? 24'hFF_FFFF : loss_q[23:0];
  end

  always_ff @(posedge clk) begin
    loss7     <= loss6;
    mag_prod6 <= 47'(md.labmag) * 47'(md.sig);
    q_prod6   <= 62'(md.sig) * 62'(llwd_pkg::ONE - md.sig);
    lab_pos6  <= md.lab_pos;
    labmag6   <= md.labmag;
    ll6       <= md.ll;
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= md.valid;
    end
  end

  // stage 7: gradient and s(1-s) rounding
  always_comb begin
    mag_sum = 48'(mag_prod6) + 48'h200_0000;
    mag_c   = (24'(mag_sum[47:26]) > 24'h80_0000) ? 24'h80_0000 : 24'(mag_sum[47:26]);
    if (lab_pos6) begin
      g_next = ~mag_c + 24'd1;
    end else if (mag_c == 24'h80_0000) begin
      g_next = 24'h7F_FFFF;
    end else begin
      g_next = mag_c;
    end
    q_sum = 63'(q_prod6) + 63'h2000_0000;
  end

  always_ff @(posedge clk) begin
    g7       <= g_next;
    q7       <= q_sum[58:30];
    ll7      <= ll6;
    lab_pos7 <= lab_pos6;
    loss8    <= loss7;
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  // stage 8: label square times s(1-s)
  always_ff @(posedge clk) begin
    curv_prod8 <= 60'(ll7) * 60'(q7);
    g8         <= g7;
    loss9      <= loss8;
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
  end

  // stage 9: result word
  assign curv_sum = 61'(curv_prod8) + 61'h20_0000_0000;

  always_ff @(posedge clk) begin
    loss_value <= loss9;
    gradient   <= $signed(g8);
    curvature  <= curv_sum[60:38];
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v8;
    end
  end

  `LLWD_ASSERT_IMP(grad_sign, clk, rst, v7 && !lab_pos7, !g7[23], "gradient negative for non-positive label")
  `LLWD_ASSERT_IMP(q_bound, clk, rst, v7, q7 <= 29'h1000_0000, "s(1-s) above one quarter")
  `LLWD_ASSERT_NXT(zero_label, clk, rst, v6 && (labmag6 == 16'd0), g7 == 24'd0,
                   "gradient nonzero for zero label")

endmodule

@@ rtl/logistic_loss_with_derivatives_core.sv @@
// channel  dir  data ports                          handshake
// item     in   label, model_score                  start, busy
// result   out  loss_value, gradient, curvature     done
//
// one word accepted per cycle; the multiplier pipeline and the two-port
// table rom set the rate, done rises once the word has passed the front, rom,
// lerp and deriv registers and the word is taken at the edge that ends the done cycle
// synchronous reset clears the valid bits only, no table clearing pass
// busy stays low and done pulses for one cycle per word, results are not held
module logistic_loss_with_derivatives_core #(
  parameter int FUNC_TABLE_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  label,
  input  logic signed [23:0]  model_score,
  output logic                done,
  output logic [23:0]         loss_value,
  output logic signed [23:0]  gradient,
  output logic [22:0]         curvature
);

  localparam int AW = $clog2(FUNC_TABLE_DEPTH + 1);

  logic                acc;
  llwd_pkg::front_t    f2;
  logic [AW-1:0]       idx2;
  llwd_pkg::rom_data_t rd;
  llwd_pkg::mid_t      md;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  llwd_front #(
    .DEPTH(FUNC_TABLE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc),
    .label       (label),
    .model_score (model_score),
    .f           (f2),
    .idx         (idx2)
  );

  llwd_rom #(
    .DEPTH(FUNC_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (idx2),
    .rd   (rd)
  );

  llwd_lerp u_lerp (
    .clk (clk),
    .rst (rst),
    .f   (f2),
    .rd  (rd),
    .md  (md)
  );

  llwd_deriv u_deriv (
    .clk        (clk),
    .rst        (rst),
    .md         (md),
    .done       (done),
    .loss_value (loss_value),
    .gradient   (gradient),
    .curvature  (curvature)
  );

endmodule
